[rtl/tuid_pkg.sv]
// ============================================================================
// tuid_pkg: shared types and constants for the term unsigned integer decoder
// Holds tag codes, parse phases, status codes and the parser state/result
// structures used by the decode step and the top level.
// ============================================================================
package tuid_pkg;

  // Tag byte codes that start an integer term.
  localparam logic [7:0] TagSmallInt = 8'd97;
  localparam logic [7:0] TagInt32    = 8'd98;
  localparam logic [7:0] TagSmallBig = 8'd110;
  localparam logic [7:0] TagLargeBig = 8'd111;

  // Number of bytes in a 32-bit field.
  localparam logic [31:0] WordBytes = 32'd4;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SMALL   = 3'd1,
    PH_INT32   = 3'd2,
    PH_ARITY8  = 3'd3,
    PH_ARITY32 = 3'd4,
    PH_SIGN    = 3'd5,
    PH_MAG     = 3'd6,
    PH_DISCARD = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADTAG = 2'd1,
    ST_NEG    = 2'd2,
    ST_OVER   = 2'd3
  } status_e;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] field_counter;
    logic [31:0] arity_value;
    logic [31:0] accumulator;
    logic [32:0] consumed_count;
  } tuid_state_t;

  typedef struct packed {
    logic [31:0] value;
    status_e     status;
    logic [32:0] bytes_used;
  } tuid_result_t;

endpackage

[rtl/tuid_step.sv]
// ============================================================================
// tuid_step: next-state logic of the term parser
// Applies one input byte to the parser state and produces the result of a
// term that completes or fails on that byte.
// ============================================================================
module tuid_step (
  input  tuid_pkg::tuid_state_t  state_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   term_start_i,
  output tuid_pkg::tuid_state_t  state_o,
  output logic                   emit_o,
  output tuid_pkg::tuid_result_t result_o
);

  tuid_pkg::tuid_state_t nxt;
  tuid_pkg::status_e     st;
  logic [31:0]           val;
  logic [31:0]           fc_inc;
  logic [31:0]           acc_shift;
  logic [31:0]           acc_or;
  logic [32:0]           cnt_inc;
  logic                  emit;

  assign fc_inc    = state_i.field_counter + 32'd1;
  assign cnt_inc   = state_i.consumed_count + 33'd1;
  assign acc_shift = {state_i.accumulator[23:0], data_byte_i};
  assign acc_or    = state_i.accumulator
                   | ({24'd0, data_byte_i} << {state_i.field_counter[1:0], 3'b000});

  always_comb begin
    nxt  = state_i;
    emit = 1'b0;
    st   = tuid_pkg::ST_OK;
    val  = 32'd0;
    if (term_start_i) begin
      nxt.consumed_count = 33'd1;
      nxt.field_counter  = 32'd0;
      nxt.arity_value    = 32'd0;
      nxt.accumulator    = 32'd0;
      case (data_byte_i)
        tuid_pkg::TagSmallInt: nxt.phase = tuid_pkg::PH_SMALL;
        tuid_pkg::TagInt32:    nxt.phase = tuid_pkg::PH_INT32;
        tuid_pkg::TagSmallBig: nxt.phase = tuid_pkg::PH_ARITY8;
        tuid_pkg::TagLargeBig: nxt.phase = tuid_pkg::PH_ARITY32;
        default: begin
          emit = 1'b1;
          st   = tuid_pkg::ST_BADTAG;
        end
      endcase
    end else if (state_i.phase != tuid_pkg::PH_IDLE &&
                 state_i.phase != tuid_pkg::PH_DISCARD) begin
      nxt.consumed_count = cnt_inc;
      case (state_i.phase)
        tuid_pkg::PH_SMALL: begin
          emit = 1'b1;
          val  = {24'd0, data_byte_i};
        end
        tuid_pkg::PH_INT32: begin
          nxt.accumulator   = acc_shift;
          nxt.field_counter = fc_inc;
          if (fc_inc >= tuid_pkg::WordBytes) begin
            emit = 1'b1;
            if (acc_shift[31]) begin
              st = tuid_pkg::ST_NEG;
            end else begin
              val = acc_shift;
            end
          end
        end
        tuid_pkg::PH_ARITY8: begin
          nxt.arity_value = {24'd0, data_byte_i};
          nxt.phase       = tuid_pkg::PH_SIGN;
        end
        tuid_pkg::PH_ARITY32: begin
          nxt.arity_value   = {state_i.arity_value[23:0], data_byte_i};
          nxt.field_counter = fc_inc;
          if (fc_inc >= tuid_pkg::WordBytes) begin
            nxt.field_counter = 32'd0;
            nxt.phase         = tuid_pkg::PH_SIGN;
          end
        end
        tuid_pkg::PH_SIGN: begin
          if (data_byte_i != 8'd0) begin
            emit = 1'b1;
            st   = tuid_pkg::ST_NEG;
          end else begin
            nxt.accumulator   = 32'd0;
            nxt.field_counter = 32'd0;
            if (state_i.arity_value == 32'd0) begin
              emit = 1'b1;
            end else begin
              nxt.phase = tuid_pkg::PH_MAG;
            end
          end
        end
        tuid_pkg::PH_MAG: begin
          if (state_i.field_counter >= tuid_pkg::WordBytes && data_byte_i != 8'd0) begin
            emit = 1'b1;
            st   = tuid_pkg::ST_OVER;
          end else begin
            if (state_i.field_counter < tuid_pkg::WordBytes) begin
              nxt.accumulator = acc_or;
            end
            nxt.field_counter = fc_inc;
            if (fc_inc == state_i.arity_value) begin
              emit = 1'b1;
              val  = nxt.accumulator;
            end
          end
        end
        default: nxt.phase = tuid_pkg::PH_DISCARD;
      endcase
    end
    if (emit) begin
      nxt.phase = (st == tuid_pkg::ST_OK) ? tuid_pkg::PH_IDLE : tuid_pkg::PH_DISCARD;
    end
  end

  assign state_o             = nxt;
  assign emit_o              = emit;
  assign result_o.value      = (st == tuid_pkg::ST_OK) ? val : 32'd0;
  assign result_o.status     = st;
  assign result_o.bytes_used = nxt.consumed_count;

endmodule

[rtl/term_unsigned_integer_decoder_unit.sv]
// ============================================================================
// term_unsigned_integer_decoder_unit: streaming integer term decoder
// Parses encoded integer terms one byte per transaction and returns the
// unsigned 32-bit value, a status code and the byte count of each term.
// ============================================================================
// Throughput: one byte per cycle while the skid entry is empty; every byte is folded
//   into the parser state in the cycle it is accepted.
// Output: the result of the byte that completes or fails the term is registered
//   into the output register, or into the skid entry while the sink stalls.
// Reset: rst_ni clears the parser to idle (awaiting a tag) and empties the
//   output and skid registers.
module term_unsigned_integer_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        term_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o,
  output logic [1:0]  status_o,
  output logic [32:0] bytes_used_o
);

  // Parser state. It advances only on an accepted input transaction.
  tuid_pkg::tuid_state_t  state_q;
  tuid_pkg::tuid_state_t  state_d;

  // Output register plus one skid entry. The skid entry catches a result
  // that is produced while the output register is held by a stalled sink,
  // so the input side never has to look at out_stall_i combinationally.
  tuid_pkg::tuid_result_t out_q;
  tuid_pkg::tuid_result_t skid_q;
  logic                   out_valid_q;
  logic                   skid_valid_q;

  tuid_pkg::tuid_result_t step_result;
  logic                   step_emit;
  logic                   in_fire;
  logic                   res_valid;
  logic                   out_free;

  tuid_step u_step (
    .state_i      (state_q),
    .data_byte_i  (data_byte_i),
    .term_start_i (term_start_i),
    .state_o      (state_d),
    .emit_o       (step_emit),
    .result_o     (step_result)
  );

  // Input is held off only while the skid entry is occupied.
  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign res_valid  = in_fire && step_emit;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= tuid_pkg::PH_IDLE;
      state_q.field_counter  <= 32'd0;
      state_q.arity_value    <= 32'd0;
      state_q.accumulator    <= 32'd0;
      state_q.consumed_count <= 33'd0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        // No input was taken this cycle, so the skid entry drains alone.
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload registers need no reset; they are qualified by the valid flags.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= step_result;
      end
    end else if (res_valid) begin
      skid_q <= step_result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = out_q.value;
  assign status_o     = out_q.status;
  assign bytes_used_o = out_q.bytes_used;

endmodule

[bench/term_unsigned_integer_decoder_unit_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// term_unsigned_integer_decoder_unit_test: self-checking bench for the decoder
// Streams integer terms byte by byte through the valid/stall input channel.
// It predicts the value, status and byte count of every term and checks
// each result transaction against the oldest prediction. Both channels
// idle and stall at random, with a long receiver hold-off and a full drain.
// ============================================================================

// Tracks the parser state of the decoder and keeps the decoded results that
// are still owed by the block, oldest first.
class term_decode_checker;
  tuid_pkg::phase_e       phase;
  logic [31:0]            field_cnt;
  logic [31:0]            arity;
  logic [31:0]            acc;
  logic [32:0]            consumed;
  tuid_pkg::tuid_result_t decoded_q[$];
  int unsigned            errors;
  int unsigned            parsed_bytes;
  int unsigned            results_checked;
  int unsigned            status_hits[4];

  function new();
    phase           = tuid_pkg::PH_IDLE;
    field_cnt       = '0;
    arity           = '0;
    acc             = '0;
    consumed        = '0;
    errors          = 0;
    parsed_bytes    = 0;
    results_checked = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
  endfunction

  function void finish_term(logic [31:0] val, tuid_pkg::status_e st);
    tuid_pkg::tuid_result_t r;
    r.value      = (st == tuid_pkg::ST_OK) ? val : 32'd0;
    r.status     = st;
    r.bytes_used = consumed;
    decoded_q.push_back(r);
    phase = (st == tuid_pkg::ST_OK) ? tuid_pkg::PH_IDLE : tuid_pkg::PH_DISCARD;
  endfunction

  // Folds one accepted input transaction into the predicted parser state.
  function void note_byte(logic [7:0] b, logic start);
    if (start) begin
      consumed  = 33'd1;
      field_cnt = '0;
      arity     = '0;
      acc       = '0;
      parsed_bytes++;
      case (b)
        tuid_pkg::TagSmallInt: phase = tuid_pkg::PH_SMALL;
        tuid_pkg::TagInt32:    phase = tuid_pkg::PH_INT32;
        tuid_pkg::TagSmallBig: phase = tuid_pkg::PH_ARITY8;
        tuid_pkg::TagLargeBig: phase = tuid_pkg::PH_ARITY32;
        default:               finish_term(32'd0, tuid_pkg::ST_BADTAG);
      endcase
      return;
    end
    if (phase == tuid_pkg::PH_IDLE || phase == tuid_pkg::PH_DISCARD) return;
    parsed_bytes++;
    consumed = consumed + 33'd1;
    case (phase)
      tuid_pkg::PH_SMALL: finish_term({24'd0, b}, tuid_pkg::ST_OK);
      tuid_pkg::PH_INT32: begin
        acc = {acc[23:0], b};
        field_cnt++;
        if (field_cnt >= tuid_pkg::WordBytes) begin
          if (acc[31]) finish_term(32'd0, tuid_pkg::ST_NEG);
          else finish_term(acc, tuid_pkg::ST_OK);
        end
      end
      tuid_pkg::PH_ARITY8: begin
        arity = {24'd0, b};
        phase = tuid_pkg::PH_SIGN;
      end
      tuid_pkg::PH_ARITY32: begin
        arity = {arity[23:0], b};
        field_cnt++;
        if (field_cnt >= tuid_pkg::WordBytes) begin
          field_cnt = '0;
          phase     = tuid_pkg::PH_SIGN;
        end
      end
      tuid_pkg::PH_SIGN: begin
        if (b != 8'd0) begin
          finish_term(32'd0, tuid_pkg::ST_NEG);
        end else begin
          acc       = '0;
          field_cnt = '0;
          if (arity == 32'd0) finish_term(32'd0, tuid_pkg::ST_OK);
          else phase = tuid_pkg::PH_MAG;
        end
      end
      tuid_pkg::PH_MAG: begin
        if (field_cnt < tuid_pkg::WordBytes) begin
          acc = acc | ({24'd0, b} << (8 * field_cnt));
        end else if (b != 8'd0) begin
          finish_term(32'd0, tuid_pkg::ST_OVER);
          return;
        end
        field_cnt++;
        if (field_cnt == arity) finish_term(acc, tuid_pkg::ST_OK);
      end
      default: phase = tuid_pkg::PH_DISCARD;
    endcase
  endfunction

  // Compares one accepted result transaction with the oldest prediction.
  function void check_result(logic [31:0] v, logic [1:0] st, logic [32:0] used);
    tuid_pkg::tuid_result_t want;
    if (decoded_q.size() == 0) begin
      errors++;
      $display("%0t: result with none expected: value=%0d status=%0d bytes_used=%0d",
               $time, v, st, used);
      return;
    end
    want = decoded_q.pop_front();
    results_checked++;
    status_hits[want.status]++;
    if (v !== want.value) begin
      errors++;
      $display("%0t: value mismatch: expected %0d, actual %0d", $time, want.value, v);
    end
    if (st !== want.status) begin
      errors++;
      $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, st);
    end
    if (used !== want.bytes_used) begin
      errors++;
      $display("%0t: bytes_used mismatch: expected %0d, actual %0d",
               $time, want.bytes_used, used);
    end
  endfunction
endclass

module term_unsigned_integer_decoder_unit_test;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned RandomBytes = 1600;
  localparam int unsigned IdlePct     = 36;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        term_start_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] value_o;
  logic [1:0]  status_o;
  logic [32:0] bytes_used_o;

  term_decode_checker decode_chk;

  // Idle rates of the two sides; the stimulus process lowers them to zero for
  // a stretch so that back-to-back traffic is covered as well.
  int unsigned send_idle_pct = IdlePct;
  int unsigned stall_pct     = IdlePct;

  // The stimulus process toggles hold_req to ask the receiver for one long
  // hold-off; the receiver counts the hold-off cycles itself.
  bit          hold_req  = 1'b0;
  bit          hold_ack  = 1'b0;
  int unsigned hold_left = 0;

  int unsigned cycle_count = 0;

  term_unsigned_integer_decoder_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .term_start_i (term_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (value_o),
    .status_o     (status_o),
    .bytes_used_o (bytes_used_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Guards against a hung handshake; the limit is many times the slowest
  // correct run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, decode_chk.decoded_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stalls, or a solid stall while a hold-off is running.
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left    = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor. Values read here are the ones that held at the clock edge, since
  // every signal changes through nonblocking updates. A result always trails
  // the byte that caused it, so the order of the two checks does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        decode_chk.check_result(value_o, status_o, bytes_used_o);
      end
      if (in_valid_i && !in_stall_o) begin
        decode_chk.note_byte(data_byte_i, term_start_i);
      end
    end
  end

  // Offers one byte and holds it until the block takes it, then idles for a
  // random number of cycles.
  task automatic put_byte(input logic [7:0] b, input logic start);
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    term_start_i <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic put_word_be(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) put_byte(w[8*i +: 8], 1'b0);
  endtask

  // Byte values leaning toward the extremes.
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return 8'h00;
    if (r < 40) return 8'hff;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 32'h0000_0000;
    if (r < 20) return 32'hffff_ffff;
    if (r < 30) return 32'h7fff_ffff;
    if (r < 40) return 32'h8000_0000;
    return $urandom;
  endfunction

  // Sends a bignum term. Only the first mag_sent magnitude bytes go out, so a
  // huge arity can be cut short and abandoned by the next term start. Some
  // terms carry a nonzero sign or a nonzero byte past the 32-bit value.
  task automatic put_bignum(input bit large_form, input logic [31:0] arity,
                            input int unsigned mag_sent);
    int unsigned n;
    int unsigned bad_pos;
    logic [7:0]  sign;
    logic [7:0]  mag;
    put_byte(large_form ? tuid_pkg::TagLargeBig : tuid_pkg::TagSmallBig, 1'b1);
    if (large_form) put_word_be(arity);
    else put_byte(arity[7:0], 1'b0);
    sign = ($urandom_range(99) < 85) ? 8'h00 : 8'($urandom_range(1, 255));
    put_byte(sign, 1'b0);
    n       = (arity < mag_sent) ? arity : mag_sent;
    bad_pos = n;
    if (n > 4 && $urandom_range(99) < 30) bad_pos = $urandom_range(4, n - 1);
    for (int unsigned i = 0; i < n; i++) begin
      if (i < 4) mag = pick_byte();
      else if (i == bad_pos) mag = 8'($urandom_range(1, 255));
      else mag = 8'h00;
      put_byte(mag, 1'b0);
    end
  endtask

  // Stops offering bytes until every predicted result has been delivered.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (decode_chk.decoded_q.size() != 0);
  endtask

  task automatic put_random_term();
    int unsigned pick;
    int unsigned r;
    logic [31:0] arity;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 14) begin
      put_byte(tuid_pkg::TagSmallInt, 1'b1);
      put_byte(pick_byte(), 1'b0);
    end else if (pick < 32) begin
      put_byte(tuid_pkg::TagInt32, 1'b1);
      put_word_be(pick_word());
    end else if (pick < 52) begin
      arity = ($urandom_range(99) < 4) ? $urandom_range(9, 255) : $urandom_range(0, 8);
      put_bignum(1'b0, arity, arity);
    end else if (pick < 70) begin
      r = $urandom_range(99);
      if (r < 85) arity = $urandom_range(0, 10);
      else if (r < 92) arity = $urandom_range(11, 300);
      else arity = $urandom;
      // Huge arities cannot be sent in full; those terms are abandoned.
      put_bignum(1'b1, arity, (arity > 300) ? $urandom_range(0, 12) : arity);
    end else if (pick < 80) begin
      do b = 8'($urandom_range(255));
      while (b == tuid_pkg::TagSmallInt || b == tuid_pkg::TagInt32 ||
             b == tuid_pkg::TagSmallBig || b == tuid_pkg::TagLargeBig);
      put_byte(b, 1'b1);
    end else if (pick < 90) begin
      // Broken term: a valid tag followed by up to three bytes, often too few.
      case ($urandom_range(3))
        0: put_byte(tuid_pkg::TagSmallInt, 1'b1);
        1: put_byte(tuid_pkg::TagInt32, 1'b1);
        2: put_byte(tuid_pkg::TagSmallBig, 1'b1);
        default: put_byte(tuid_pkg::TagLargeBig, 1'b1);
      endcase
      repeat ($urandom_range(0, 3)) put_byte(pick_byte(), 1'b0);
    end else begin
      // Loose bytes with no tag; ignored unless a term is still open.
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  initial begin
    bit drained;
    bit held;
    bit quiet_done;
    decode_chk   = new();
    drained      = 1'b0;
    held         = 1'b0;
    quiet_done   = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = 8'h00;
    term_start_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: field extremes, every tag but the large bignum one, and the special cases.
    put_byte(tuid_pkg::TagSmallInt, 1'b1);  // small integer at its maximum
    put_byte(8'hff, 1'b0);
    put_byte(tuid_pkg::TagInt32, 1'b1);     // largest positive 32-bit integer
    put_word_be(32'h7fff_ffff);
    put_byte(tuid_pkg::TagInt32, 1'b1);     // most negative one is rejected
    put_word_be(32'h8000_0000);
    put_byte(8'hff, 1'b1);                  // unknown tag
    put_byte(8'h00, 1'b0);                  // dropped while discarding
    put_byte(tuid_pkg::TagSmallBig, 1'b1);  // bignum of arity zero
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(tuid_pkg::TagSmallBig, 1'b1);  // bignum with a negative sign
    put_byte(8'h01, 1'b0);
    put_byte(8'h01, 1'b0);
    put_byte(tuid_pkg::TagSmallBig, 1'b1);  // fifth magnitude byte overflows
    put_byte(8'h05, 1'b0);
    put_byte(8'h00, 1'b0);
    put_word_be(32'hffff_ffff);
    put_byte(8'h01, 1'b0);
    put_byte(tuid_pkg::TagInt32, 1'b1);     // restarted in mid-term
    put_byte(8'h12, 1'b0);
    put_byte(tuid_pkg::TagSmallInt, 1'b1);
    put_byte(8'h00, 1'b0);
    put_byte(8'h5a, 1'b0);                  // loose byte while idle

    // Random part, with a drain, a long receiver hold-off and a stretch with
    // no idling on either side along the way.
    while (decode_chk.parsed_bytes < RandomBytes) begin
      if (!drained && decode_chk.parsed_bytes >= 400) begin
        drained = 1'b1;
        drain_results();
      end
      if (!held && decode_chk.parsed_bytes >= 800) begin
        held          = 1'b1;
        hold_req      = ~hold_req;
        send_idle_pct = 0;
        repeat (40) begin
          put_byte(tuid_pkg::TagSmallInt, 1'b1);
          put_byte(pick_byte(), 1'b0);
        end
        send_idle_pct = IdlePct;
      end
      if (decode_chk.parsed_bytes >= 1100 && decode_chk.parsed_bytes < 1350) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end else if (!quiet_done && decode_chk.parsed_bytes >= 1350) begin
        quiet_done    = 1'b1;
        send_idle_pct = IdlePct;
        stall_pct     = IdlePct;
      end
      put_random_term();
    end

    drain_results();
    repeat (4) @(posedge clk_i);

    $display("Parsed %0d term bytes and checked %0d results in %0d cycles.",
             decode_chk.parsed_bytes, decode_chk.results_checked, cycle_count);
    $display("Results by status: ok %0d, unknown tag %0d, negative %0d, overflow %0d.",
             decode_chk.status_hits[tuid_pkg::ST_OK],
             decode_chk.status_hits[tuid_pkg::ST_BADTAG],
             decode_chk.status_hits[tuid_pkg::ST_NEG],
             decode_chk.status_hits[tuid_pkg::ST_OVER]);
    if (decode_chk.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[term_unsigned_integer_decoder_unit.f]
rtl/tuid_pkg.sv
rtl/tuid_step.sv
rtl/term_unsigned_integer_decoder_unit.sv
bench/term_unsigned_integer_decoder_unit_test.sv
